// ===== design/bbe_pkg.sv =====
package bbe_pkg;

   localparam int BLOCK_W     = 64;
   localparam int KEY_HALF_W  = 64;
   localparam int IDX_W       = 5;
   localparam int ROUND_COUNT = 25;

   // Configuration register indexes
   localparam logic CSR_KEY_UPPER = 1'b0;
   localparam logic CSR_KEY_LOWER = 1'b1;

   // 4-bit substitution box
   function automatic logic [3:0] sbox(input logic [3:0] nib);
      logic [3:0] r;
      case (nib)
         4'h0: r = 4'he;
         4'h1: r = 4'h4;
         4'h2: r = 4'hb;
         4'h3: r = 4'h1;
         4'h4: r = 4'h7;
         4'h5: r = 4'h9;
         4'h6: r = 4'hc;
         4'h7: r = 4'ha;
         4'h8: r = 4'hd;
         4'h9: r = 4'h2;
         4'ha: r = 4'h0;
         4'hb: r = 4'hf;
         4'hc: r = 4'h8;
         4'hd: r = 4'h5;
         4'he: r = 4'h3;
         default: r = 4'h6;
      endcase
      return r;
   endfunction

endpackage

// ===== design/bbe_round.sv =====
module bbe_round
   import bbe_pkg::*;
(
   input  logic [BLOCK_W-1:0]    state_word,
   input  logic [KEY_HALF_W-1:0] round_key,
   output logic [BLOCK_W-1:0]    next_word
);

   logic [BLOCK_W-1:0] keyed;
   logic [BLOCK_W-1:0] subbed;
   logic [BLOCK_W-1:0] swapped;
   logic [15:0]        w3, w2, w1, w0;
   logic [15:0]        y1, y2, y3, y4;

   assign keyed = state_word ^ round_key;

   always_comb begin
      for (int n = 0; n < 16; n++) begin
         subbed[4*n +: 4] = sbox(keyed[4*n +: 4]);
      end
      for (int w = 0; w < 4; w++) begin
         swapped[16*w +: 16] = {subbed[16*w +: 8], subbed[16*w+8 +: 8]};
      end
   end

   // rotate words left by 9, 7, 4 and 1, most significant word first
   assign w3 = {swapped[54:48], swapped[63:55]};
   assign w2 = {swapped[40:32], swapped[47:41]};
   assign w1 = {swapped[27:16], swapped[31:28]};
   assign w0 = {swapped[14:0],  swapped[15]};

   // word mixing layer
   assign y2 = w2 ^ w0;
   assign y1 = w3 ^ y2;
   assign y3 = w3 ^ w1;
   assign y4 = y3 ^ w0;

   assign next_word = {y1, y2, y3, y4};

endmodule

// ===== design/bbe_key_step.sv =====
module bbe_key_step
   import bbe_pkg::*;
(
   input  logic [KEY_HALF_W-1:0] key_hi,
   input  logic [KEY_HALF_W-1:0] key_lo,
   input  logic [IDX_W-1:0]      round_idx,
   output logic [KEY_HALF_W-1:0] next_hi,
   output logic [KEY_HALF_W-1:0] next_lo
);

   logic [KEY_HALF_W-1:0] rot_lo;

   // rotate the full key left by 13
   assign next_hi = {key_hi[50:0], key_lo[63:51]};
   assign rot_lo  = {key_lo[50:0], key_hi[63:51]};

   // substitute the lowest byte, fold the round index into the top bits
   assign next_lo = {rot_lo[63:59] ^ round_idx, rot_lo[58:8],
                     sbox(rot_lo[7:4]), sbox(rot_lo[3:0])};

endmodule

// ===== design/boron_block_encrypt_core.sv =====
// Channel  Direction  Ports                                  Word
// req      in         req_valid, req_stall, req_plaintext     64-bit plaintext block
// rsp      out        rsp_valid, rsp_stall, rsp_ciphertext    64-bit ciphertext block
// csr      in         csr_write_enable, csr_index, csr_write_data   key halves
//
// A block is loaded, then runs through its rounds in the single shared round and
// key-step unit; no new block is taken until the sequencer returns to idle.
// The last round cycle also adds the final round key into the output register.
// Reset is synchronous and active high; it clears the key registers and control.
// A finished word waits in the output register, so the next word is taken while
// it is stalled; the sequencer holds in its last round until that register frees.
module boron_block_encrypt_core
   import bbe_pkg::*;
#(
   parameter int ROUND_COUNT_P = ROUND_COUNT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BLOCK_W-1:0] req_plaintext,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BLOCK_W-1:0] rsp_ciphertext,

   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [KEY_HALF_W-1:0] csr_write_data
);

   localparam int RND_W = (ROUND_COUNT_P > 1) ? $clog2(ROUND_COUNT_P) : 1;
   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT_P - 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   seq_state_type          seq_ff, seq_in;
   logic [RND_W-1:0]       round_ff, round_in;
   logic [BLOCK_W-1:0]     block_ff, block_in;
   logic [KEY_HALF_W-1:0]  work_hi_ff, work_hi_in;
   logic [KEY_HALF_W-1:0]  work_lo_ff, work_lo_in;
   logic [KEY_HALF_W-1:0]  key_upper_ff, key_upper_in;
   logic [KEY_HALF_W-1:0]  key_lower_ff, key_lower_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [BLOCK_W-1:0]     round_out;
   logic [KEY_HALF_W-1:0]  step_hi, step_lo;
   logic                   req_take;
   logic                   out_free;
   logic                   finish;

   bbe_round u_round (
      .state_word (block_ff),
      .round_key  (work_lo_ff),
      .next_word  (round_out)
   );

   bbe_key_step u_key_step (
      .key_hi    (work_hi_ff),
      .key_lo    (work_lo_ff),
      .round_idx (IDX_W'(round_ff)),
      .next_hi   (step_hi),
      .next_lo   (step_lo)
   );

   assign req_stall = (seq_ff == ST_RUN);
   assign req_take  = req_valid && (seq_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (seq_ff == ST_RUN) && (round_ff == LAST_ROUND) && out_free;

   always_comb begin
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_UPPER: key_upper_in = csr_write_data;
            CSR_KEY_LOWER: key_lower_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      seq_in       = seq_ff;
      round_in     = round_ff;
      block_in     = block_ff;
      work_hi_in   = work_hi_ff;
      work_lo_in   = work_lo_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (seq_ff)
         ST_IDLE: begin
            // load the block and a fresh copy of the key
            if (req_take) begin
               block_in   = req_plaintext;
               work_hi_in = key_upper_ff;
               work_lo_in = key_lower_ff;
               round_in   = '0;
               seq_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (round_ff != LAST_ROUND) begin
               // advance one round and one key step
               block_in   = round_out;
               work_hi_in = step_hi;
               work_lo_in = step_lo;
               round_in   = round_ff + 1'b1;
            end else if (finish) begin
               // final key addition straight into the output register
               rsp_data_in  = round_out ^ step_lo;
               rsp_valid_in = 1'b1;
               seq_in       = ST_IDLE;
            end
         end
         default: seq_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else begin
         seq_ff       <= seq_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
      end
      block_ff    <= block_in;
      work_hi_ff  <= work_hi_in;
      work_lo_ff  <= work_lo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_data_ff;

endmodule
